### hw/rtl/tpcq_pkg.sv
// ----------------------------------------------------------------------------
// tpcq_pkg
// Shared constants, codes and types of the three-class priority call queue.
// ----------------------------------------------------------------------------
package tpcq_pkg;

    localparam int CLASS_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int NUM_CLASSES = 3;

    localparam int PTR_W = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int REM_W = $clog2(MAX_RESULTS + 1);

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 2;
    localparam int NUM_W    = 24;
    localparam int PKT_W    = 16;

    // Command queue between front and back; depth is a power of two
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_ENQ_DATA  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENQ_VOICE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ENQ_EMERG = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SERVE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DISMISS   = 3'd4;

    localparam logic [CLASS_W-1:0] CLS_DATA  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_VOICE = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_EMERG = 2'd2;

    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISMISSED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_DISMISS = 3'd5;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_SERVE   = 2'd1,
        OP_DISMISS = 2'd2
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CLASS_W-1:0] cls;
        logic [NUM_W-1:0]   calling;
        logic [NUM_W-1:0]   called;
        logic [PKT_W-1:0]   packets;
        logic               cid;
        logic               roam;
    } cmd_t;

    // Ring index base + offs, with base < CLASS_DEPTH and offs <= CLASS_DEPTH
    function automatic logic [PTR_W-1:0] ring_idx(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(offs);
        if (s >= SUM_W'(CLASS_DEPTH))
        begin
            s = s - SUM_W'(CLASS_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

### hw/rtl/tpcq_front.sv
// ----------------------------------------------------------------------------
// tpcq_front
// Accepts input transactions, decodes the kind and pushes a command.
// ----------------------------------------------------------------------------
module tpcq_front import tpcq_pkg::*;
(
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [NUM_W-1:0]   calling_number,
    input  logic [NUM_W-1:0]   called_number,
    input  logic [PKT_W-1:0]   packet_count,
    input  logic               show_caller_id,
    input  logic               roaming_flag,
    input  logic               q_full,
    output logic               push,
    output cmd_t               push_cmd
);

    logic known;

    assign cmd_ready = !q_full;

    always_comb
    begin
        known            = 1'b1;
        push_cmd.op      = OP_ENQ;
        push_cmd.cls     = CLS_DATA;
        push_cmd.calling = calling_number;
        push_cmd.called  = called_number;
        push_cmd.packets = '0;
        push_cmd.cid     = 1'b0;
        push_cmd.roam    = 1'b0;
        case (kind) inside
            [KIND_ENQ_DATA:KIND_ENQ_EMERG]:
            begin
                push_cmd.op  = OP_ENQ;
                push_cmd.cls = kind[CLASS_W-1:0];
                // zero the fields that do not belong to the class
                if (kind == KIND_ENQ_DATA)
                begin
                    push_cmd.packets = packet_count;
                end
                if (kind == KIND_ENQ_VOICE)
                begin
                    push_cmd.cid  = show_caller_id;
                    push_cmd.roam = roaming_flag;
                end
            end
            KIND_SERVE:   push_cmd.op = OP_SERVE;
            KIND_DISMISS: push_cmd.op = OP_DISMISS;
            default:      known = 1'b0;
        endcase
    end

    // drop undefined kinds after the transaction
    assign push = cmd_valid && cmd_ready && known;

endmodule

### hw/rtl/tpcq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tpcq_cmd_fifo
// Short command queue that decouples the front decoder from the sequencer.
// ----------------------------------------------------------------------------
module tpcq_cmd_fifo import tpcq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] fill_reg, fill_next;
    logic                  do_push, do_pop;

    assign full     = (fill_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/tpcq_back.sv
// ----------------------------------------------------------------------------
// tpcq_back
// Sequencer: class rings, head and count state, and the result register.
// ----------------------------------------------------------------------------
module tpcq_back import tpcq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                cmd_avail,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [STATUS_W-1:0] status,
    output logic [CLASS_W-1:0]  call_class,
    output logic [NUM_W-1:0]    out_calling,
    output logic [NUM_W-1:0]    out_called,
    output logic [PKT_W-1:0]    out_packets,
    output logic                out_caller_id,
    output logic                out_roaming,
    output logic                last
);

    localparam int EMERG_W = 2 * NUM_W;
    localparam int VOICE_W = 2 * NUM_W + 2;
    localparam int DATA_W  = 2 * NUM_W + PKT_W;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_READ = 2'b10
    } seq_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  cls;
        logic [NUM_W-1:0]    calling;
        logic [NUM_W-1:0]    called;
        logic [PKT_W-1:0]    packets;
        logic                cid;
        logic                roam;
        logic                last;
    } res_t;

    logic [EMERG_W-1:0] emerg_mem [CLASS_DEPTH];
    logic [VOICE_W-1:0] voice_mem [CLASS_DEPTH];
    logic [DATA_W-1:0]  data_mem  [CLASS_DEPTH];
    logic [EMERG_W-1:0] emerg_rd_reg;
    logic [VOICE_W-1:0] voice_rd_reg;
    logic [DATA_W-1:0]  data_rd_reg;

    seq_state_t         state_reg, state_next;
    logic [PTR_W-1:0]   head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]   head_next [NUM_CLASSES];
    logic [CNT_W-1:0]   count_reg  [NUM_CLASSES];
    logic [CNT_W-1:0]   count_next [NUM_CLASSES];
    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic               dismiss_reg, dismiss_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg;

    logic               out_free;
    logic               load;
    res_t               ld;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_idx;
    logic               rd_en;
    logic [CLASS_W-1:0] rd_cls;
    logic [PTR_W-1:0]   rd_idx;
    logic               emerg_any, voice_any, data_any;
    logic [CLASS_W-1:0] sel;

    assign out_free  = !res_valid_reg || res_ready;
    assign emerg_any = (count_reg[CLS_EMERG] != '0);
    assign voice_any = (count_reg[CLS_VOICE] != '0);
    assign data_any  = (count_reg[CLS_DATA] != '0);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cls_next     = cls_reg;
        dismiss_next = dismiss_reg;
        rem_next     = rem_reg;
        pop          = 1'b0;
        load         = 1'b0;
        ld           = '0;
        ld.last      = 1'b1;
        wr_en        = 1'b0;
        wr_idx       = '0;
        rd_en        = 1'b0;
        rd_cls       = cls_reg;
        rd_idx       = '0;
        sel          = CLS_DATA;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (cmd_avail && out_free)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        OP_ENQ:
                        begin
                            load   = 1'b1;
                            ld.cls = cmd.cls;
                            if (count_reg[cmd.cls] == CNT_W'(CLASS_DEPTH))
                            begin
                                ld.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_idx     = ring_idx(head_reg[cmd.cls], count_reg[cmd.cls]);
                                count_next[cmd.cls] = count_reg[cmd.cls] + 1'b1;
                                ld.status  = ST_QUEUED;
                                ld.calling = cmd.calling;
                                ld.called  = cmd.called;
                                ld.packets = cmd.packets;
                                ld.cid     = cmd.cid;
                                ld.roam    = cmd.roam;
                            end
                        end
                        OP_SERVE:
                        begin
                            if (!emerg_any && !voice_any && !data_any)
                            begin
                                load      = 1'b1;
                                ld.status = ST_EMPTY;
                            end
                            else
                            begin
                                sel = emerg_any ? CLS_EMERG : (voice_any ? CLS_VOICE : CLS_DATA);
                                rd_en           = 1'b1;
                                rd_cls          = sel;
                                rd_idx          = head_reg[sel];
                                head_next[sel]  = ring_idx(head_reg[sel], CNT_W'(1));
                                count_next[sel] = count_reg[sel] - 1'b1;
                                cls_next        = sel;
                                dismiss_next    = 1'b0;
                                state_next      = SEQ_READ;
                            end
                        end
                        OP_DISMISS:
                        begin
                            if (data_any || voice_any)
                            begin
                                sel = data_any ? CLS_DATA : CLS_VOICE;
                                rd_en           = 1'b1;
                                rd_cls          = sel;
                                rd_idx = ring_idx(head_reg[sel], count_reg[sel] - 1'b1);
                                count_next[sel] = count_reg[sel] - 1'b1;
                                cls_next        = sel;
                                dismiss_next    = 1'b1;
                                // newest calls only, up to the result limit
                                if (int'(count_reg[sel]) > MAX_RESULTS)
                                begin
                                    rem_next = REM_W'(MAX_RESULTS);
                                end
                                else
                                begin
                                    rem_next = REM_W'(count_reg[sel]);
                                end
                                state_next = SEQ_READ;
                            end
                            else if (emerg_any)
                            begin
                                load      = 1'b1;
                                ld.status = ST_NO_DISMISS;
                                ld.cls    = CLS_EMERG;
                            end
                            else
                            begin
                                load      = 1'b1;
                                ld.status = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            SEQ_READ:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    ld.cls    = cls_reg;
                    ld.status = dismiss_reg ? ST_DISMISSED : ST_SERVED;
                    ld.last   = !dismiss_reg || (rem_reg == REM_W'(1));
                    case (cls_reg)
                        CLS_EMERG:
                        begin
                            ld.calling = emerg_rd_reg[EMERG_W-1 -: NUM_W];
                            ld.called  = emerg_rd_reg[NUM_W-1:0];
                        end
                        CLS_VOICE:
                        begin
                            ld.calling = voice_rd_reg[VOICE_W-1 -: NUM_W];
                            ld.called  = voice_rd_reg[VOICE_W-NUM_W-1 -: NUM_W];
                            ld.cid     = voice_rd_reg[1];
                            ld.roam    = voice_rd_reg[0];
                        end
                        default:
                        begin
                            ld.calling = data_rd_reg[DATA_W-1 -: NUM_W];
                            ld.called  = data_rd_reg[DATA_W-NUM_W-1 -: NUM_W];
                            ld.packets = data_rd_reg[PKT_W-1:0];
                        end
                    endcase
                    // fetch the next newest call while this one goes out
                    if (dismiss_reg && (rem_reg != REM_W'(1)))
                    begin
                        rd_en  = 1'b1;
                        rd_idx = ring_idx(head_reg[cls_reg], count_reg[cls_reg] - 1'b1);
                        count_next[cls_reg] = count_reg[cls_reg] - 1'b1;
                        rem_next = rem_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = SEQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            cls_reg       <= CLS_DATA;
            dismiss_reg   <= 1'b0;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cls_reg       <= cls_next;
            dismiss_reg   <= dismiss_next;
            rem_reg       <= rem_next;
            res_valid_reg <= res_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= ld;
        end
    end

    // class rings: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_en && (cmd.cls == CLS_EMERG))
        begin
            emerg_mem[wr_idx] <= {cmd.calling, cmd.called};
        end
        if (wr_en && (cmd.cls == CLS_VOICE))
        begin
            voice_mem[wr_idx] <= {cmd.calling, cmd.called, cmd.cid, cmd.roam};
        end
        if (wr_en && (cmd.cls == CLS_DATA))
        begin
            data_mem[wr_idx] <= {cmd.calling, cmd.called, cmd.packets};
        end
        if (rd_en && (rd_cls == CLS_EMERG))
        begin
            emerg_rd_reg <= emerg_mem[rd_idx];
        end
        if (rd_en && (rd_cls == CLS_VOICE))
        begin
            voice_rd_reg <= voice_mem[rd_idx];
        end
        if (rd_en && (rd_cls == CLS_DATA))
        begin
            data_rd_reg <= data_mem[rd_idx];
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = res_reg.status;
    assign call_class    = res_reg.cls;
    assign out_calling   = res_reg.calling;
    assign out_called    = res_reg.called;
    assign out_packets   = res_reg.packets;
    assign out_caller_id = res_reg.cid;
    assign out_roaming   = res_reg.roam;
    assign last          = res_reg.last;

endmodule

### hw/rtl/three_class_priority_call_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_call_queue
// Strict priority call queue with emergency, voice and data classes.
// ----------------------------------------------------------------------------
// A decoder takes each input transaction, drops undefined kinds, and pushes a
// command into a two-entry queue; a sequencer behind it owns three ring
// memories of CLASS_DEPTH calls and a result register. Once the sequencer
// picks a command, an enqueue or a status-only result is loaded straight into
// the result register, a serve goes through one registered ring read first,
// and a dismiss of N calls does one ring read per call, newest first, while
// each result waits to be taken. The sequencer stalls only on a full result
// register, and the input side keeps taking transactions until the command
// queue fills. The ring contents are undefined after reset; only counted
// entries are read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module three_class_priority_call_queue import tpcq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [NUM_W-1:0]    calling_number,
    input  logic [NUM_W-1:0]    called_number,
    input  logic [PKT_W-1:0]    packet_count,
    input  logic                show_caller_id,
    input  logic                roaming_flag,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [STATUS_W-1:0] status,
    output logic [CLASS_W-1:0]  call_class,
    output logic [NUM_W-1:0]    out_calling,
    output logic [NUM_W-1:0]    out_called,
    output logic [PKT_W-1:0]    out_packets,
    output logic                out_caller_id,
    output logic                out_roaming,
    output logic                last
);

    logic push, pop, q_full, q_empty;
    cmd_t push_cmd, head_cmd;

    tpcq_front u_front (
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .kind           (kind),
        .calling_number (calling_number),
        .called_number  (called_number),
        .packet_count   (packet_count),
        .show_caller_id (show_caller_id),
        .roaming_flag   (roaming_flag),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    tpcq_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    tpcq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (head_cmd),
        .cmd_avail     (!q_empty),
        .pop           (pop),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .status        (status),
        .call_class    (call_class),
        .out_calling   (out_calling),
        .out_called    (out_called),
        .out_packets   (out_packets),
        .out_caller_id (out_caller_id),
        .out_roaming   (out_roaming),
        .last          (last)
    );

endmodule
